// ===== hw/rtl/vmlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertical median line cleaner package
// Shared constants, register indexes, configuration and per-request control
// types of the vertical median line cleaner.
// ----------------------------------------------------------------------------
package vmlc_pkg;

   localparam int ROW_W          = 12;
   localparam int MAX_ROWS       = 4096;
   localparam int MIN_ROWS       = 5;
   localparam int MIN_BITS       = 8;
   localparam int LINE_CMP_W     = 14;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = 2;
   localparam int QUEUE_LVL_W    = 3;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 13;

   localparam logic [1:0]  RESET_MODE   = 2'd1;
   localparam logic [12:0] RESET_WIDTH  = 13'd1920;
   localparam logic [12:0] RESET_HEIGHT = 13'd1080;
   localparam logic [4:0]  RESET_BITS   = 5'd8;

   localparam logic [1:0] MODE_COPY   = 2'd0;
   localparam logic [1:0] MODE_MEDIAN = 2'd1;
   localparam logic [1:0] MODE_CLIP   = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE   = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2,
      CSR_BITS   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_COPY   = 2'd0,
      OP_MEDIAN = 2'd1,
      OP_CLIP   = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [12:0] line_width;
      logic [12:0] frame_height;
      logic [4:0]  sample_bits;
   } cfg_type;

   typedef struct packed {
      op_type op_top;
      op_type op_mid;
      op_type op_bot;
      logic   last;
      logic   row_end;
   } ctrl_type;

endpackage

// ===== hw/rtl/vertical_median_line_cleaner.sv =====
// ----------------------------------------------------------------------------
// Vertical median line cleaner
// Samples enter in raster order on the req_ queue port (push/full) and cleaned
// samples leave on the rsp_ queue port (empty/pop), two rows behind the input.
// Registers are written on the csr_ port (valid/ready, index, data). The user
// must write them only while the block is idle; the block does not enforce
// this, and csr_ready is always high.
// Throughput: one sample per cycle while req_full is low. Each sample of the
// last row yields three results on the single result port, so the last row
// is taken at a lower rate. Rows 0 and 1 give no result.
// A sample of row r >= 2 passes the line store read, the request queue and the
// three-stage clip pipeline before it gives its first result.
// The front end and the back end are parted by a four-entry request queue;
// when the receiver stalls, the result register holds, the back end stops and
// full rises once the queue fills.
// Reset clears the counters, the queue and the pipeline and restores the
// register defaults; the line stores are not cleared and hold no meaning
// until the first two rows of a plane are written.
// ----------------------------------------------------------------------------
module vertical_median_line_cleaner #(
   parameter int MAX_LINE_SAMPLES = 4096,
   parameter int SAMPLE_WIDTH     = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [SAMPLE_WIDTH-1:0]            req_input_sample,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [SAMPLE_WIDTH-1:0]            rsp_output_sample,
   output logic                               rsp_last_of_run,
   output logic                               rsp_frame_end,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vmlc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [vmlc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import vmlc_pkg::*;

   localparam int SW = SAMPLE_WIDTH;

   cfg_type                cfg_ff;
   logic                   q_push, q_pop, q_empty;
   ctrl_type               q_push_ctrl, q_head_ctrl;
   logic [5*SW-1:0]        q_push_window, q_head_window;
   logic [QUEUE_LVL_W-1:0] q_level;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= RESET_MODE;
         cfg_ff.line_width   <= RESET_WIDTH;
         cfg_ff.frame_height <= RESET_HEIGHT;
         cfg_ff.sample_bits  <= RESET_BITS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE:   cfg_ff.mode         <= csr_data[1:0];
            CSR_WIDTH:  cfg_ff.line_width   <= csr_data[12:0];
            CSR_HEIGHT: cfg_ff.frame_height <= csr_data[12:0];
            CSR_BITS:   cfg_ff.sample_bits  <= csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   vmlc_front #(
      .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES),
      .SAMPLE_WIDTH     (SAMPLE_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_input_sample (req_input_sample),
      .q_level          (q_level),
      .q_push           (q_push),
      .q_ctrl           (q_push_ctrl),
      .q_window         (q_push_window)
   );

   vmlc_queue #(
      .DATA_W    (5 * SAMPLE_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_ctrl (q_push_ctrl),
      .push_data (q_push_window),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_ctrl (q_head_ctrl),
      .head_data (q_head_window),
      .level     (q_level)
   );

   vmlc_back #(
      .SAMPLE_WIDTH      (SAMPLE_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .sample_bits       (cfg_ff.sample_bits),
      .q_empty           (q_empty),
      .q_ctrl            (q_head_ctrl),
      .q_window          (q_head_window),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_output_sample (rsp_output_sample),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_frame_end     (rsp_frame_end)
   );

   a_queue_level: assert property (@(posedge clock) disable iff (reset)
      q_level <= QUEUE_LVL_W'(QUEUE_DEPTH))
      else $error("request queue level beyond depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_level < QUEUE_LVL_W'(QUEUE_DEPTH))
      else $error("request pushed into a full queue");

   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> rsp_last_of_run)
      else $error("frame end on a result that does not close its request");

   a_reset_drains: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("pipeline not drained after reset");

endmodule

// ===== hw/rtl/vmlc_front.sv =====
// ----------------------------------------------------------------------------
// Vertical median line cleaner front end
// Accepts samples, keeps the column and row counters and the four line
// stores, and forwards the five-row column window with its row operations.
// ----------------------------------------------------------------------------
module vmlc_front #(
   parameter int MAX_LINE_SAMPLES = 4096,
   parameter int SAMPLE_WIDTH     = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  vmlc_pkg::cfg_type                   cfg,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [SAMPLE_WIDTH-1:0]             req_input_sample,
   input  logic [vmlc_pkg::QUEUE_LVL_W-1:0]    q_level,
   output logic                                q_push,
   output vmlc_pkg::ctrl_type                  q_ctrl,
   output logic [5*SAMPLE_WIDTH-1:0]           q_window
);
   import vmlc_pkg::*;

   localparam int XW = $clog2(MAX_LINE_SAMPLES);
   localparam int SW = SAMPLE_WIDTH;
   localparam int WW = 4 * SW;
   localparam logic [LINE_CMP_W-1:0] MAX_W = LINE_CMP_W'(MAX_LINE_SAMPLES);
   localparam int LQ = QUEUE_LVL_W + 1;

   logic [WW-1:0]         line_mem [MAX_LINE_SAMPLES];

   logic [XW-1:0]         col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic                  st1_valid_ff;
   logic                  st1_emit_ff;
   logic [XW-1:0]         st1_x_ff;
   logic [SW-1:0]         st1_s_ff;
   ctrl_type              st1_ctrl_ff;
   logic [WW-1:0]         rd_ff;
   logic                  byp_ff;
   logic [WW-1:0]         byp_word_ff;

   logic                  accept;
   logic [LINE_CMP_W-1:0] w_raw, w_eff;
   logic [12:0]           h_eff;
   logic [ROW_W-1:0]      hm1, hm2;
   logic                  last, row_end, emit;
   ctrl_type              ctrl_in;
   logic [WW-1:0]         word_use, new_word;

   function automatic op_type row_op(input logic [ROW_W-1:0] y, input logic [1:0] mode,
                                     input logic [ROW_W-1:0] lim1,
                                     input logic [ROW_W-1:0] lim2);
      op_type op;
      case (mode)
         MODE_MEDIAN: begin
            op = (y == '0 || y >= lim1) ? OP_COPY : OP_MEDIAN;
         end
         MODE_CLIP: begin
            op = (y < ROW_W'(2) || y >= lim2) ? OP_COPY : OP_CLIP;
         end
         default: begin
            op = OP_COPY;
         end
      endcase
      return op;
   endfunction

   assign accept = req_push & ~req_full;

   always_comb begin
      w_raw = LINE_CMP_W'(cfg.line_width);
      if (w_raw == '0) begin
         w_eff = LINE_CMP_W'(1);
      end else if (w_raw > MAX_W) begin
         w_eff = MAX_W;
      end else begin
         w_eff = w_raw;
      end
      if (cfg.frame_height < 13'(MIN_ROWS)) begin
         h_eff = 13'(MIN_ROWS);
      end else if (cfg.frame_height > 13'(MAX_ROWS)) begin
         h_eff = 13'(MAX_ROWS);
      end else begin
         h_eff = cfg.frame_height;
      end
      hm1     = ROW_W'(h_eff - 13'd1);
      hm2     = ROW_W'(h_eff - 13'd2);
      last    = row_ff >= hm1;
      row_end = (LINE_CMP_W'(col_ff) + LINE_CMP_W'(1)) >= w_eff;
      emit    = row_ff >= ROW_W'(2);

      ctrl_in.op_top  = row_op(row_ff - ROW_W'(2), cfg.mode, hm1, hm2);
      ctrl_in.op_mid  = row_op(row_ff - ROW_W'(1), cfg.mode, hm1, hm2);
      ctrl_in.op_bot  = row_op(row_ff, cfg.mode, hm1, hm2);
      ctrl_in.last    = last;
      ctrl_in.row_end = row_end;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
   end

   // forward the word written at the edge that issued this read
   assign word_use = byp_ff ? byp_word_ff : rd_ff;
   assign new_word = {word_use[3*SW-1:0], st1_s_ff};

   assign q_push   = st1_valid_ff & st1_emit_ff;
   assign q_ctrl   = st1_ctrl_ff;
   assign q_window = {word_use, st1_s_ff};

   assign req_full = (LQ'(q_level) + LQ'(st1_valid_ff & st1_emit_ff)) >= LQ'(QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         st1_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         st1_valid_ff <= accept;
         byp_ff       <= accept & st1_valid_ff & (st1_x_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st1_x_ff    <= col_ff;
         st1_s_ff    <= req_input_sample;
         st1_ctrl_ff <= ctrl_in;
         st1_emit_ff <= emit;
      end
      byp_word_ff <= new_word;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_ff];
      end
      if (st1_valid_ff) begin
         line_mem[st1_x_ff] <= new_word;
      end
   end

endmodule

// ===== hw/rtl/vmlc_queue.sv =====
// ----------------------------------------------------------------------------
// Vertical median line cleaner request queue
// Short queue of column windows between the front end and the back end.
// ----------------------------------------------------------------------------
module vmlc_queue #(
   parameter int DATA_W = 80
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  vmlc_pkg::ctrl_type                push_ctrl,
   input  logic [DATA_W-1:0]                 push_data,
   input  logic                              pop,
   output logic                              empty,
   output vmlc_pkg::ctrl_type                head_ctrl,
   output logic [DATA_W-1:0]                 head_data,
   output logic [vmlc_pkg::QUEUE_LVL_W-1:0]  level
);
   import vmlc_pkg::*;

   ctrl_type                ctrl_ff [QUEUE_DEPTH];
   logic [DATA_W-1:0]       data_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_LVL_W-1:0]  level_ff;
   logic                    do_pop;

   assign empty     = level_ff == '0;
   assign level     = level_ff;
   assign head_ctrl = ctrl_ff[rd_ptr_ff];
   assign head_data = data_ff[rd_ptr_ff];
   assign do_pop    = pop & ~empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (push && !do_pop) begin
            level_ff <= level_ff + QUEUE_LVL_W'(1);
         end else if (!push && do_pop) begin
            level_ff <= level_ff - QUEUE_LVL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctrl_ff[wr_ptr_ff] <= push_ctrl;
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/vmlc_back.sv =====
// ----------------------------------------------------------------------------
// Vertical median line cleaner back end
// Expands each request into one or three rows and runs the copy, median and
// relaxed clip through a three-stage pipeline into the result register.
// ----------------------------------------------------------------------------
module vmlc_back #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [4:0]                 sample_bits,
   input  logic                       q_empty,
   input  vmlc_pkg::ctrl_type         q_ctrl,
   input  logic [5*SAMPLE_WIDTH-1:0]  q_window,
   output logic                       q_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [SAMPLE_WIDTH-1:0]    rsp_output_sample,
   output logic                       rsp_last_of_run,
   output logic                       rsp_frame_end
);
   import vmlc_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam logic [1:0] PHASE_TOP = 2'd0;
   localparam logic [1:0] PHASE_MID = 2'd1;
   localparam logic [1:0] PHASE_BOT = 2'd2;

   logic [1:0]    phase_ff, phase_in;
   logic          adv, issue, last_phase;
   logic [4:0]    bits_eff;
   logic [SW:0]   one_shift;
   logic [SW-1:0] ceil_v;
   logic [SW-1:0] w0, w1, w2, w3, w4;
   logic [SW-1:0] sel_a2, sel_a1, sel_c, sel_b1, sel_b2;
   op_type        sel_op;
   logic          sel_lor, sel_fe;

   logic          s1_valid_ff;
   logic [SW-1:0] s1_c_ff, s1_a1_ff, s1_b1_ff;
   logic [SW-1:0] s1_au_ff, s1_ad_ff, s1_bu_ff, s1_bd_ff;
   op_type        s1_op_ff;
   logic          s1_lor_ff, s1_fe_ff;

   logic          s2_valid_ff;
   logic [SW-1:0] s2_c_ff, s2_a1_ff, s2_b1_ff;
   logic [SW-1:0] s2_upa_ff, s2_upb_ff, s2_loa_ff, s2_lob_ff, s2_med_ff;
   op_type        s2_op_ff;
   logic          s2_lor_ff, s2_fe_ff;

   logic          s3_valid_ff;
   logic [SW-1:0] s3_sample_ff, s3_sample_in;
   logic          s3_lor_ff, s3_fe_ff;
   logic [SW-1:0] up, lo, clip;

   function automatic logic signed [SW+1:0] ext(input logic [SW-1:0] v);
      return $signed({2'b00, v});
   endfunction

   function automatic logic [SW-1:0] sat(input logic signed [SW+1:0] v,
                                         input logic [SW-1:0] cl);
      logic [SW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > ext(cl)) begin
         r = cl;
      end else begin
         r = v[SW-1:0];
      end
      return r;
   endfunction

   function automatic logic [SW-1:0] umin(input logic [SW-1:0] a, input logic [SW-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [SW-1:0] umax(input logic [SW-1:0] a, input logic [SW-1:0] b);
      return (a > b) ? a : b;
   endfunction

   always_comb begin
      if (sample_bits < 5'(MIN_BITS)) begin
         bits_eff = 5'(MIN_BITS);
      end else if (sample_bits > 5'(SW)) begin
         bits_eff = 5'(SW);
      end else begin
         bits_eff = sample_bits;
      end
      one_shift = (SW+1)'(1) << bits_eff;
      ceil_v    = SW'(one_shift - (SW+1)'(1));
   end

   // advance the whole back end while the result register can move
   assign adv        = ~s3_valid_ff | rsp_pop;
   assign issue      = adv & ~q_empty;
   assign last_phase = ~q_ctrl.last | (phase_ff == PHASE_BOT);
   assign q_pop      = issue & last_phase;
   assign phase_in   = last_phase ? PHASE_TOP : phase_ff + 2'd1;

   assign w0 = q_window[5*SW-1:4*SW];
   assign w1 = q_window[4*SW-1:3*SW];
   assign w2 = q_window[3*SW-1:2*SW];
   assign w3 = q_window[2*SW-1:SW];
   assign w4 = q_window[SW-1:0];

   always_comb begin
      case (phase_ff)
         PHASE_TOP: begin
            sel_a2  = w0;
            sel_a1  = w1;
            sel_c   = w2;
            sel_b1  = w3;
            sel_b2  = w4;
            sel_op  = q_ctrl.op_top;
            sel_lor = ~q_ctrl.last;
            sel_fe  = 1'b0;
         end
         PHASE_MID: begin
            sel_a2  = w1;
            sel_a1  = w2;
            sel_c   = w3;
            sel_b1  = w4;
            sel_b2  = '0;
            sel_op  = q_ctrl.op_mid;
            sel_lor = 1'b0;
            sel_fe  = 1'b0;
         end
         default: begin
            sel_a2  = w2;
            sel_a1  = w3;
            sel_c   = w4;
            sel_b1  = '0;
            sel_b2  = '0;
            sel_op  = q_ctrl.op_bot;
            sel_lor = 1'b1;
            sel_fe  = q_ctrl.row_end;
         end
      endcase
   end

   always_comb begin
      up   = umax(umax(umin(s2_upa_ff, s2_upb_ff), s2_a1_ff), s2_b1_ff);
      lo   = umin(umin(s2_a1_ff, s2_b1_ff), umax(s2_loa_ff, s2_lob_ff));
      clip = (s2_c_ff < lo) ? lo : ((s2_c_ff > up) ? up : s2_c_ff);
      case (s2_op_ff)
         OP_MEDIAN: s3_sample_in = s2_med_ff;
         OP_CLIP:   s3_sample_in = clip;
         default:   s3_sample_in = s2_c_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_TOP;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         if (issue) begin
            phase_ff <= phase_in;
         end
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_c_ff   <= sel_c;
         s1_a1_ff  <= sel_a1;
         s1_b1_ff  <= sel_b1;
         s1_au_ff  <= sat(ext(sel_a1) - ext(sel_a2), ceil_v);
         s1_ad_ff  <= sat(ext(sel_a2) - ext(sel_a1), ceil_v);
         s1_bu_ff  <= sat(ext(sel_b1) - ext(sel_b2), ceil_v);
         s1_bd_ff  <= sat(ext(sel_b2) - ext(sel_b1), ceil_v);
         s1_op_ff  <= sel_op;
         s1_lor_ff <= sel_lor;
         s1_fe_ff  <= sel_fe;

         s2_c_ff   <= s1_c_ff;
         s2_a1_ff  <= s1_a1_ff;
         s2_b1_ff  <= s1_b1_ff;
         s2_upa_ff <= sat(ext(s1_au_ff) + ext(s1_a1_ff), ceil_v);
         s2_upb_ff <= sat(ext(s1_bu_ff) + ext(s1_b1_ff), ceil_v);
         s2_loa_ff <= sat(ext(s1_a1_ff) - ext(s1_ad_ff), ceil_v);
         s2_lob_ff <= sat(ext(s1_b1_ff) - ext(s1_bd_ff), ceil_v);
         s2_med_ff <= umin(umax(umin(s1_a1_ff, s1_b1_ff), s1_c_ff),
                           umax(s1_a1_ff, s1_b1_ff));
         s2_op_ff  <= s1_op_ff;
         s2_lor_ff <= s1_lor_ff;
         s2_fe_ff  <= s1_fe_ff;

         s3_sample_ff <= s3_sample_in;
         s3_lor_ff    <= s2_lor_ff;
         s3_fe_ff     <= s2_fe_ff;
      end
   end

   assign rsp_empty         = ~s3_valid_ff;
   assign rsp_output_sample = s3_sample_ff;
   assign rsp_last_of_run   = s3_lor_ff;
   assign rsp_frame_end     = s3_fe_ff;

endmodule
